/* hdl/midi_note_tracker_panic_core_assert.svh */
// Assertion macros for the MIDI note tracker with panic sequencer.
`ifndef MIDI_NOTE_TRACKER_PANIC_CORE_ASSERT_SVH
`define MIDI_NOTE_TRACKER_PANIC_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MNTP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define MNTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MNTP_ASSERT_NOW(label, clk, rst, ante, cons)
`define MNTP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/mntp_pkg.sv */
// Shared types and constants for the MIDI note tracker with panic sequencer.
`timescale 1ns / 1ps

package mntp_pkg;

  // Status byte high nibbles
  localparam logic [3:0] NOTE_OFF_HI = 4'h8;
  localparam logic [3:0] NOTE_ON_HI  = 4'h9;
  localparam logic [3:0] CTRL_HI     = 4'hB;

  // All-notes-off controller number and data byte mask
  localparam logic [7:0] CC_ALL_NOTES_OFF = 8'h7B;
  localparam logic [7:0] DATA_MASK        = 8'h7F;

  // Item kinds
  localparam logic KIND_MSG   = 1'b0;
  localparam logic KIND_PANIC = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic scan;     // resolve the target note and the action flag
    logic read;     // read the note row
    logic commit;   // write back the row and load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

/* hdl/mntp_ctrl.sv */
// Sequencing state machine: idle, scan, read, write-back.
`timescale 1ns / 1ps

module mntp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mntp_pkg::status_t status,
  output mntp_pkg::cmd_t   cmd
);
  import mntp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.commit = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/mntp_dpath.sv */
// Note bitmap memory, busy vector, pending-note search and output register.
`timescale 1ns / 1ps

module mntp_dpath #(
  parameter int NOTE_COUNT    = 128,
  parameter int CHANNEL_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mntp_pkg::cmd_t    cmd,
  output mntp_pkg::status_t status,
  input  logic              kind,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        data_one,
  input  logic [7:0]        data_two,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_status,
  output logic [7:0]        out_data_one,
  output logic [7:0]        out_data_two,
  output logic              panic_last
);
  import mntp_pkg::*;

  localparam int NW     = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int GROUPS = (NOTE_COUNT + 15) / 16;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW     = CHANNEL_COUNT;

  // Lowest set bit of a 16-bit slice
  function automatic logic [3:0] lowest16(input logic [15:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  // Captured transaction
  logic       kind_q;
  logic [7:0] stat_q;
  logic [7:0] d1_q;
  logic [7:0] d2_q;

  // Row storage; a row whose busy bit is clear reads as zero
  logic [CW-1:0]         note_map [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] note_busy;
  logic [CW-1:0]         rd_row;
  logic                  rd_live;

  logic [3:0] panic_channel;

  // Group summary, registered every cycle
  logic [GROUPS*16-1:0] busy_pad;
  logic [GROUPS-1:0]    grp_any;
  logic [3:0]           grp_off [GROUPS];

  logic [NW-1:0] key_q;
  logic          act_q;

  assign busy_pad = (GROUPS*16)'(note_busy);

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any[g] <= |busy_pad[g*16 +: 16];
      grp_off[g] <= lowest16(busy_pad[g*16 +: 16]);
    end
  end

  // Lowest busy group
  logic [GW-1:0]   grp_sel;
  logic [GW+3:0]   pend_key;
  logic            pend_any;

  always_comb begin
    grp_sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = GW'(g);
    end
    pend_any = |grp_any;
    pend_key = {grp_sel, grp_off[grp_sel]};
  end

  // Message tracking decode
  logic [6:0] msg_key;
  logic [3:0] msg_ch;
  logic       msg_note;
  logic       msg_track;

  assign msg_key   = d1_q[6:0];
  assign msg_ch    = stat_q[3:0];
  assign msg_note  = (stat_q[7:4] == NOTE_ON_HI) || (stat_q[7:4] == NOTE_OFF_HI);
  assign msg_track = msg_note && (int'(msg_key) < NOTE_COUNT) &&
                     (int'(msg_ch) < CHANNEL_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      stat_q <= status_byte;
      d1_q   <= data_one;
      d2_q   <= data_two;
    end
    if (cmd.scan) begin
      if (kind_q == KIND_PANIC) begin
        key_q <= pend_key[NW-1:0];
        act_q <= pend_any;
      end else begin
        key_q <= NW'(msg_key);
        act_q <= msg_track;
      end
    end
    if (cmd.read) begin
      rd_row  <= note_map[key_q];
      rd_live <= note_busy[key_q];
    end
  end

  // Row update and result selection
  logic [CW-1:0] row;
  logic [CW-1:0] row_next;
  logic [3:0]    low_ch;
  logic [CW-1:0] ch_bit;
  logic [7:0]    res_status;
  logic [7:0]    res_d1;
  logic [7:0]    res_d2;
  logic          res_last;
  logic          row_wr;
  logic          off_last;

  always_comb begin
    row    = rd_live ? rd_row : '0;
    low_ch = 4'd15;
    for (int i = CW - 1; i >= 0; i--) begin
      if (row[i]) low_ch = 4'(i);
    end
    off_last   = int'(panic_channel) >= CHANNEL_COUNT - 1;
    row_next   = row;
    row_wr     = 1'b0;
    ch_bit     = '0;
    res_status = stat_q;
    res_d1     = d1_q;
    res_d2     = d2_q;
    res_last   = 1'b0;
    if (kind_q == KIND_MSG) begin
      ch_bit = CW'(1) << msg_ch;
      row_wr = act_q;
      if ((stat_q[7:4] == NOTE_ON_HI) && (d2_q != 8'd0)) begin
        row_next = row | ch_bit;
      end else begin
        row_next = row & ~ch_bit;
      end
    end else if (act_q) begin
      ch_bit     = CW'(1) << low_ch;
      row_wr     = 1'b1;
      row_next   = row & ~ch_bit;
      res_status = {NOTE_ON_HI, low_ch};
      res_d1     = 8'(key_q) & DATA_MASK;
      res_d2     = 8'd0;
    end else begin
      res_status = {CTRL_HI, panic_channel};
      res_d1     = CC_ALL_NOTES_OFF;
      res_d2     = 8'd0;
      res_last   = off_last;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (cmd.commit && row_wr) begin
      note_map[key_q] <= row_next;
    end
  end

  // Busy vector, panic channel and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      note_busy     <= '0;
      panic_channel <= 4'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit && row_wr) begin
        note_busy[key_q] <= |row_next;
      end
      if (cmd.commit && (kind_q == KIND_PANIC) && !act_q) begin
        panic_channel <= off_last ? 4'd0 : panic_channel + 4'd1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status   <= res_status;
      out_data_one <= res_d1;
      out_data_two <= res_d2;
      panic_last   <= res_last;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

/* hdl/midi_note_tracker_panic_core.sv */
// Top level of the MIDI note tracker with panic sequencer.
`timescale 1ns / 1ps
//
// Usage:
//  Input channel (in_valid/in_stall) carries one transaction per item: kind 0
//  is a short MIDI message that is passed through and tracked, kind 1 is one
//  panic step. Every input transaction yields exactly one output transaction
//  (out_valid/out_stall) with the message to send and panic_last.
//  Panic steps first release pending notes, lowest note then lowest channel,
//  as note-on velocity 0; after that one all-notes-off per channel, the last
//  flagged with panic_last.
//  Each item passes the scan, read and write-back states before out_valid
//  rises; no new item is taken until the last is written back, a limit of
//  the single-port row read-modify-write of the note bitmap memory and the
//  registered busy group search. in_stall is high while an item is in flight.
//  Output stall: the result sits in the output register; the next item is
//  still accepted and runs until its write-back, which waits for the slot.
//  Reset (rst, synchronous): clears the busy vector, which marks every row as
//  empty, the panic channel and the output valid. No clearing pass is needed;
//  an item can be accepted in the first cycle after reset.
//
module midi_note_tracker_panic_core #(
  parameter int NOTE_COUNT    = 128,
  parameter int CHANNEL_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] status_byte,
  input  logic [7:0] data_one,
  input  logic [7:0] data_two,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_status,
  output logic [7:0] out_data_one,
  output logic [7:0] out_data_two,
  output logic       panic_last
);
  import mntp_pkg::*;

  `include "midi_note_tracker_panic_core_assert.svh"

  cmd_t    cmd;
  status_t status;

  // Sequencer
  mntp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Bitmap storage, search and output register
  mntp_dpath #(
    .NOTE_COUNT    (NOTE_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .status_byte  (status_byte),
    .data_one     (data_one),
    .data_two     (data_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_one (out_data_one),
    .out_data_two (out_data_two),
    .panic_last   (panic_last)
  );

  // An accepted item keeps the input stalled while it is processed.
  `MNTP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // A result is only produced by an item in flight.
  `MNTP_ASSERT_NOW(a_result_from_item, clk, rst, $rose(out_valid), $past(in_stall))

  // The final panic message is always an all-notes-off controller message.
  `MNTP_ASSERT_NOW(a_last_is_all_off, clk, rst, out_valid && panic_last,
                   (out_status[7:4] == CTRL_HI) && (out_data_one == CC_ALL_NOTES_OFF))

  // Commands come one at a time.
  `MNTP_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the MIDI note tracker with panic sequencer.
`timescale 1ns / 1ps

module testbench;
  import mntp_pkg::*;

  localparam int NOTES = 128;
  localparam int CHANS = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT = 1000;   // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 120;   // long output hold-off to back the block up
  localparam int DRAIN_CYCLES = 16;   // settling time past the last result

  // One input transaction and one output transaction, as the ports carry them.
  typedef struct packed {
    logic       kind;
    logic [7:0] stat;
    logic [7:0] d1;
    logic [7:0] d2;
  } midi_item_t;

  typedef struct packed {
    logic [7:0] stat;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       last;
  } midi_msg_t;

  // Directed row: when fixed is set the typed-in result is owed instead of
  // the predicted one (the predictor still tracks the item).
  typedef struct packed {
    midi_item_t item;
    logic       fixed;
    midi_msg_t  res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = KIND_MSG;
  logic [7:0] status_byte = 8'h00;
  logic [7:0] data_one = 8'h00;
  logic [7:0] data_two = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_status;
  logic [7:0] out_data_one;
  logic [7:0] out_data_two;
  logic       panic_last;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_note_tracker_panic_core #(
    .NOTE_COUNT   (NOTES),
    .CHANNEL_COUNT(CHANS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_data_one(out_data_one),
    .out_data_two(out_data_two),
    .panic_last  (panic_last)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block state: which notes are sounding on which channels,
  // and the next channel for the all-notes-off sweep.
  // ---------------------------------------------------------------------------
  logic [CHANS-1:0] sounding [NOTES];
  logic [4:0]       aof_chan;

  midi_msg_t owed_msgs [$];   // messages the block still has to emit, in order
  int        mismatch_count = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;

  function automatic int pending_notes();
    int n;
    int total;
    total = 0;
    for (n = 0; n < NOTES; n++) total += $countones(sounding[n]);
    return total;
  endfunction

  // Message emitted for one accepted item; updates the shadow state.
  function automatic midi_msg_t next_midi_out(input midi_item_t it);
    midi_msg_t r;
    int        key;
    int        ch;
    int        n;
    int        c;
    bit        found;
    r = '0;
    found = 1'b0;
    key = 0;
    ch = 0;
    if (it.kind == KIND_MSG) begin
      // pass-through, then track note-on / note-off on the masked note number
      r.stat = it.stat;
      r.d1 = it.d1;
      r.d2 = it.d2;
      key = int'(it.d1 & DATA_MASK);
      ch = int'(it.stat[3:0]);
      if (key < NOTES && ch < CHANS) begin
        if (it.stat[7:4] == NOTE_ON_HI && it.d2 != 8'h00)
          sounding[key][ch] = 1'b1;
        else if (it.stat[7:4] == NOTE_OFF_HI || it.stat[7:4] == NOTE_ON_HI)
          sounding[key][ch] = 1'b0;
      end
    end else begin
      for (n = 0; n < NOTES && !found; n++) begin
        if (sounding[n] != '0) begin
          found = 1'b1;
          key = n;
        end
      end
      if (found) begin
        // release lowest note on its lowest channel
        for (c = CHANS - 1; c >= 0; c--) if (sounding[key][c]) ch = c;
        r.stat = {NOTE_ON_HI, 4'(ch)};
        r.d1 = 8'(key) & DATA_MASK;
        r.d2 = 8'h00;
        sounding[key][ch] = 1'b0;
      end else begin
        r.stat = {CTRL_HI, aof_chan[3:0]};
        r.d1 = CC_ALL_NOTES_OFF;
        r.d2 = 8'h00;
        r.last = (int'(aof_chan[3:0]) >= CHANS - 1);
        aof_chan = r.last ? 5'd0 : aof_chan + 5'd1;
      end
    end
    return r;
  endfunction

  // Random short message, weighted toward note traffic on a small pool of
  // notes so that note-offs actually hit sounding notes.
  function automatic midi_item_t rand_message();
    midi_item_t it;
    int         pick;
    logic [3:0] ch;
    logic [6:0] key;
    pick = $urandom_range(0, 99);
    ch = 4'($urandom_range(0, CHANS - 1));
    key = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, NOTES - 1))
                                      : 7'($urandom_range(0, 9));
    it.kind = KIND_MSG;
    it.d1 = {1'($urandom_range(0, 1)), key};
    it.d2 = 8'($urandom_range(1, 255));
    if (pick < 50) begin
      it.stat = {NOTE_ON_HI, ch};
    end else if (pick < 70) begin
      it.stat = {NOTE_OFF_HI, ch};
      it.d2 = 8'($urandom_range(0, 255));
    end else if (pick < 80) begin
      it.stat = {NOTE_ON_HI, ch};
      it.d2 = 8'h00;
    end else begin
      it.stat = 8'($urandom_range(0, 255));
      it.d1 = 8'($urandom_range(0, 255));
      it.d2 = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  function automatic midi_item_t rand_panic();
    midi_item_t it;
    it.kind = KIND_PANIC;
    it.stat = 8'($urandom_range(0, 255));
    it.d1 = 8'($urandom_range(0, 255));
    it.d2 = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one input transaction in bursts with random gaps; once it is taken,
  // record the message it owes. Called and returns on a rising edge.
  task automatic offer_item(input midi_item_t it, input logic fixed, input midi_msg_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= it.kind;
    status_byte <= it.stat;
    data_one <= it.d1;
    data_two <= it.d2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = fixed ? res : next_midi_out(it);
    if (fixed) void'(next_midi_out(it));
    owed_msgs.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %02h, want %02h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Notes set on the lowest and highest note numbers, a
  // masked note byte, note-off and zero-velocity clears, a controller that is
  // not tracked, then a panic run: three releases, the all-notes-off sweep
  // with a message slipped in mid-sweep, and the flagged final channel.
  // ---------------------------------------------------------------------------
  stim_row_t dir_table [28] = '{
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd0}, 8'h00, 8'h7F}, 1'b1,
      '{{NOTE_ON_HI, 4'd0}, 8'h00, 8'h7F, 1'b0}},
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd15}, 8'hFF, 8'h01}, 1'b1,
      '{{NOTE_ON_HI, 4'd15}, 8'hFF, 8'h01, 1'b0}},
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd14}, 8'hFF, 8'h22}, 1'b1,
      '{{NOTE_ON_HI, 4'd14}, 8'hFF, 8'h22, 1'b0}},
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd5}, 8'h3C, 8'h40}, 1'b1,
      '{{NOTE_ON_HI, 4'd5}, 8'h3C, 8'h40, 1'b0}},
    '{'{KIND_MSG, {NOTE_OFF_HI, 4'd5}, 8'h3C, 8'h00}, 1'b1,
      '{{NOTE_OFF_HI, 4'd5}, 8'h3C, 8'h00, 1'b0}},
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd14}, 8'h7F, 8'h00}, 1'b0, '0},
    '{'{KIND_MSG, {CTRL_HI, 4'd2}, 8'h05, 8'h60}, 1'b1,
      '{{CTRL_HI, 4'd2}, 8'h05, 8'h60, 1'b0}},
    '{'{KIND_MSG, {NOTE_ON_HI, 4'd7}, 8'h80, 8'h7F}, 1'b0, '0},
    // releases: note 0 on channels 0 and 7, then note 127 on channel 15
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{NOTE_ON_HI, 4'd0}, 8'h00, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{{NOTE_ON_HI, 4'd7}, 8'h00, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{NOTE_ON_HI, 4'd15}, 8'h7F, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd0}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd1}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    // tracked mid-sweep; the sweep resumes at channel 2
    '{'{KIND_MSG, {NOTE_OFF_HI, 4'd10}, 8'h40, 8'h50}, 1'b0, '0},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd2}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd3}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd4}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd5}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd6}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd7}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd8}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd9}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd10}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd11}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd12}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd13}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'h00, 8'h00, 8'h00}, 1'b1, '{{CTRL_HI, 4'd14}, CC_ALL_NOTES_OFF, 8'h00, 1'b0}},
    '{'{KIND_PANIC, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{{CTRL_HI, 4'd15}, CC_ALL_NOTES_OFF, 8'h00, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random episodes. Each episode is a
  // few messages followed by no panic, a short partial panic run, or a run
  // long enough to release every sounding note and finish the sweep.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int  i;
    int  sent;
    int  panics;
    bit  hold_used;
    for (i = 0; i < NOTES; i++) sounding[i] = '0;
    aof_chan = '0;
    sent = 0;
    hold_used = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) offer_item(dir_table[i].item, dir_table[i].fixed, dir_table[i].res);

    while (sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 12)) begin
        offer_item(rand_message(), 1'b0, '0);
        sent++;
      end
      case ($urandom_range(0, 3))
        0: panics = pending_notes() + CHANS - int'(aof_chan);
        1: panics = 0;
        default: panics = $urandom_range(1, 6);
      endcase
      repeat (panics) begin
        offer_item(rand_panic(), 1'b0, '0);
        sent++;
      end
      // one long output hold-off while items keep coming
      if (sent >= 100 && !hold_used) begin
        hold_req = 1'b1;
        hold_used = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (owed_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output stall pattern: segments of random length, each clean, lightly
  // stalled, heavily stalled or toggling; the long hold-off overrides it.
  // ---------------------------------------------------------------------------
  initial begin : out_stall_gen
    int mode;
    int seg_left;
    int hold_left;
    mode = 0;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Output checker: every output transaction against the oldest owed message.
  always @(posedge clk) begin : out_check
    midi_msg_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_msgs.size() == 0) begin
        report_mismatch("unowed out_status", out_status, 0);
      end else begin
        want = owed_msgs.pop_front();
        if (out_status !== want.stat) report_mismatch("out_status", out_status, want.stat);
        if (out_data_one !== want.d1) report_mismatch("out_data_one", out_data_one, want.d1);
        if (out_data_two !== want.d2) report_mismatch("out_data_two", out_data_two, want.d2);
        if (panic_last !== want.last) report_mismatch("panic_last", panic_last, want.last);
      end
    end
  end

  // Watchdog: ends the run when neither side moves a transaction for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle = 0;
      else
        idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mntp_pkg.sv
hdl/mntp_ctrl.sv
hdl/mntp_dpath.sv
hdl/midi_note_tracker_panic_core.sv
verif/testbench.sv
